// ----- hw/rtl/priority_ready_queue_scheduler_defines.svh -----
// assertion macros for the priority ready queue scheduler
// used by prqs_ctrl, the rtl file that checks its own logic
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define PRQS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("prqs check failed");
`define PRQS_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("prqs never failed");
`else
`define PRQS_ASSERT(lbl, clk, rst, prop)
`define PRQS_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- hw/rtl/prqs_pkg.sv -----
// shared types and constants of the priority ready queue scheduler
// no dependencies
package prqs_pkg;

  localparam int NUM_TASKS = 16;
  localparam int NUM_PRIO  = 8;
  localparam int T_W       = 4;
  localparam int P_W       = 3;
  localparam int PF_W      = 4;
  localparam int STACK_W   = 16;
  localparam int CNT_W     = 5;
  localparam logic [T_W-1:0] IDLE_SLOT = 4'd0;

  typedef enum logic [1:0] {
    CMD_READY = 2'd0,
    CMD_YIELD = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    TS_DORMANT = 2'd0,
    TS_READY   = 2'd1,
    TS_RUNNING = 2'd2,
    TS_BLOCKED = 2'd3
  } task_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MARK_READY,
    OP_LOAD,
    OP_YIELD_SAVE,
    OP_ENQ,
    OP_DEQ_RD,
    OP_DEQ,
    OP_STK_RD
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic yield_requeue;
  } sts_t;

endpackage

// ----- hw/rtl/prqs_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module prqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/prqs_ctrl.sv -----
// control state machine of the scheduler: sequences the datapath steps
// depends on prqs_pkg and the defines header
`include "priority_ready_queue_scheduler_defines.svh"
module prqs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  prqs_pkg::sts_t sts,
  output prqs_pkg::ctl_t ctl,
  output logic           busy,
  output logic           done
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MARK, S_LOAD, S_SAVE, S_ENQ, S_DEQ_RD, S_DEQ, S_STK_RD, S_OUT
  } state_t;

  state_t state;

  always_comb begin
    unique case (state)
      S_IDLE:   ctl.op = start ? prqs_pkg::OP_CAPTURE : prqs_pkg::OP_NONE;
      S_MARK:   ctl.op = prqs_pkg::OP_MARK_READY;
      S_LOAD:   ctl.op = prqs_pkg::OP_LOAD;
      S_SAVE:   ctl.op = prqs_pkg::OP_YIELD_SAVE;
      S_ENQ:    ctl.op = prqs_pkg::OP_ENQ;
      S_DEQ_RD: ctl.op = prqs_pkg::OP_DEQ_RD;
      S_DEQ:    ctl.op = prqs_pkg::OP_DEQ;
      S_STK_RD: ctl.op = prqs_pkg::OP_STK_RD;
      default:  ctl.op = prqs_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (sts.cmd)
            prqs_pkg::CMD_READY: state <= S_MARK;
            prqs_pkg::CMD_YIELD: state <= S_SAVE;
            prqs_pkg::CMD_LOAD:  state <= S_LOAD;
            default:             state <= S_STK_RD;
          endcase
        end
        S_MARK:   state <= S_ENQ;
        S_LOAD:   state <= S_STK_RD;
        S_SAVE:   state <= sts.yield_requeue ? S_ENQ : S_DEQ_RD;
        S_ENQ:    state <= (sts.cmd == prqs_pkg::CMD_YIELD) ? S_DEQ_RD : S_STK_RD;
        S_DEQ_RD: state <= S_DEQ;
        S_DEQ:    state <= S_STK_RD;
        S_STK_RD: begin
          state <= S_OUT;
          done  <= 1'b1;
        end
        S_OUT: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  `PRQS_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `PRQS_ASSERT(a_done_single, clk, rst, done |=> !done)
  `PRQS_NEVER(a_done_idle, clk, rst, done && !busy)

endmodule

// ----- hw/rtl/prqs_dp.sv -----
// scheduler datapath: task tables, ready lists, running task and result
// depends on prqs_pkg and prqs_ram
module prqs_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  prqs_pkg::ctl_t                  ctl,
  input  logic [1:0]                      cmd,
  input  logic [prqs_pkg::T_W-1:0]        task_id,
  input  logic [prqs_pkg::PF_W-1:0]       task_priority,
  input  logic [prqs_pkg::STACK_W-1:0]    stack_value,
  input  logic                            stack_ok,
  output prqs_pkg::sts_t                  sts,
  output logic                            status_code,
  output logic [prqs_pkg::T_W-1:0]        next_task,
  output logic [prqs_pkg::STACK_W-1:0]    next_stack,
  output logic                            idle_chosen
);

  prqs_pkg::cmd_t                 cmd_q;
  logic [prqs_pkg::T_W-1:0]       tid_q;
  logic [prqs_pkg::PF_W-1:0]      prio_q;
  logic [prqs_pkg::STACK_W-1:0]   sv_q;
  logic                           ok_q;
  logic [prqs_pkg::T_W-1:0]       tgt;
  logic [prqs_pkg::T_W-1:0]       run_task;
  logic                           run_valid;
  prqs_pkg::task_state_t          task_status [prqs_pkg::NUM_TASKS];
  logic                           queued [prqs_pkg::NUM_TASKS];
  logic [prqs_pkg::T_W-1:0]       head [prqs_pkg::NUM_PRIO];
  logic [prqs_pkg::T_W-1:0]       tail [prqs_pkg::NUM_PRIO];
  logic [prqs_pkg::CNT_W-1:0]     cnt  [prqs_pkg::NUM_PRIO];
  logic                           found_q;
  logic [prqs_pkg::P_W-1:0]       pe_q;

  logic                           found;
  logic [prqs_pkg::P_W-1:0]       pe;
  logic [prqs_pkg::PF_W-1:0]      prio_rdata;
  logic [prqs_pkg::T_W-1:0]       link_rdata;
  logic [prqs_pkg::STACK_W-1:0]   stk_rdata;
  logic [prqs_pkg::P_W-1:0]       pl;
  logic                           oor;
  logic                           stk_we;
  logic                           link_we;

  // lowest-numbered non-empty list
  always_comb begin
    found = 1'b0;
    pe    = '0;
    for (int i = prqs_pkg::NUM_PRIO - 1; i >= 0; i--) begin
      if (cnt[i] != '0) begin
        found = 1'b1;
        pe    = prqs_pkg::P_W'(i);
      end
    end
  end

  assign pl  = prio_rdata[prqs_pkg::P_W-1:0];
  assign oor = prio_rdata >= prqs_pkg::PF_W'(prqs_pkg::NUM_PRIO);

  assign stk_we  = (ctl.op == prqs_pkg::OP_LOAD) ||
                   (ctl.op == prqs_pkg::OP_YIELD_SAVE && run_valid && sv_q != '0);
  assign link_we = (ctl.op == prqs_pkg::OP_ENQ) && !oor && !queued[tgt] && cnt[pl] != '0;

  prqs_ram #(.WIDTH(prqs_pkg::STACK_W), .DEPTH(prqs_pkg::NUM_TASKS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr ((ctl.op == prqs_pkg::OP_LOAD) ? tid_q : run_task),
    .wdata (sv_q),
    .raddr (run_task),
    .rdata (stk_rdata)
  );

  prqs_ram #(.WIDTH(prqs_pkg::PF_W), .DEPTH(prqs_pkg::NUM_TASKS)) u_prio (
    .clk   (clk),
    .we    (ctl.op == prqs_pkg::OP_LOAD),
    .waddr (tid_q),
    .wdata (prio_q),
    .raddr ((ctl.op == prqs_pkg::OP_MARK_READY) ? tid_q : run_task),
    .rdata (prio_rdata)
  );

  prqs_ram #(.WIDTH(prqs_pkg::T_W), .DEPTH(prqs_pkg::NUM_TASKS)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (tail[pl]),
    .wdata (tgt),
    .raddr (head[pe]),
    .rdata (link_rdata)
  );

  assign sts.cmd           = cmd_q;
  assign sts.yield_requeue = run_valid && run_task != prqs_pkg::IDLE_SLOT && ok_q &&
                             task_status[run_task] == prqs_pkg::TS_RUNNING;

  assign next_task  = run_task;
  assign next_stack = run_valid ? stk_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_task  <= prqs_pkg::IDLE_SLOT;
      run_valid <= 1'b0;
      for (int i = 0; i < prqs_pkg::NUM_TASKS; i++) begin
        task_status[i] <= prqs_pkg::TS_DORMANT;
        queued[i]      <= 1'b0;
      end
      for (int i = 0; i < prqs_pkg::NUM_PRIO; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      unique case (ctl.op)
        prqs_pkg::OP_CAPTURE: begin
          cmd_q       <= prqs_pkg::cmd_t'(cmd);
          tid_q       <= task_id;
          prio_q      <= task_priority;
          sv_q        <= stack_value;
          ok_q        <= stack_ok;
          status_code <= 1'b0;
          idle_chosen <= 1'b0;
        end
        prqs_pkg::OP_MARK_READY: begin
          task_status[tid_q] <= prqs_pkg::TS_READY;
          tgt                <= tid_q;
        end
        prqs_pkg::OP_YIELD_SAVE: begin
          tgt <= run_task;
          if (run_valid) begin
            if (run_task != prqs_pkg::IDLE_SLOT) begin
              if (!ok_q) begin
                task_status[run_task] <= prqs_pkg::TS_BLOCKED;
              end else if (task_status[run_task] == prqs_pkg::TS_RUNNING) begin
                task_status[run_task] <= prqs_pkg::TS_READY;
              end
            end else begin
              task_status[run_task] <= prqs_pkg::TS_READY;
            end
          end
        end
        prqs_pkg::OP_ENQ: begin
          if (cmd_q == prqs_pkg::CMD_READY) begin
            status_code <= oor;
          end
          if (!oor && !queued[tgt]) begin
            if (cnt[pl] == '0) begin
              head[pl] <= tgt;
            end
            tail[pl]    <= tgt;
            cnt[pl]     <= cnt[pl] + 1'b1;
            queued[tgt] <= 1'b1;
          end
        end
        prqs_pkg::OP_DEQ_RD: begin
          found_q     <= found;
          pe_q        <= pe;
          idle_chosen <= !found;
          run_task    <= found ? head[pe] : prqs_pkg::IDLE_SLOT;
        end
        prqs_pkg::OP_DEQ: begin
          if (found_q) begin
            head[pe_q]       <= link_rdata;
            cnt[pe_q]        <= cnt[pe_q] - 1'b1;
            queued[run_task] <= 1'b0;
          end
          task_status[run_task] <= prqs_pkg::TS_RUNNING;
          run_valid             <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/priority_ready_queue_scheduler.sv -----
// priority ready queue scheduler: top level, controller plus datapath
// a new command is taken only once busy has dropped; a yield adds an enqueue
// step when the running task is requeued
// done marks the result for one cycle, in the cycle before busy drops; no stall
// synchronous active-high reset empties all ready lists, all tasks dormant,
// no task running, no clearing pass; depends on prqs_pkg, prqs_ctrl, prqs_dp
module priority_ready_queue_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [3:0]  task_id,
  input  logic [3:0]  task_priority,
  input  logic [15:0] stack_value,
  input  logic        stack_ok,
  output logic        done,
  output logic        status_code,
  output logic [3:0]  next_task,
  output logic [15:0] next_stack,
  output logic        idle_chosen
);

  // command and status between the sequencer and the tables
  prqs_pkg::ctl_t ctl;
  prqs_pkg::sts_t sts;

  // sequencer: one step of table access per cycle
  prqs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  // task tables, ready lists and the result registers
  prqs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cmd           (cmd),
    .task_id       (task_id),
    .task_priority (task_priority),
    .stack_value   (stack_value),
    .stack_ok      (stack_ok),
    .sts           (sts),
    .status_code   (status_code),
    .next_task     (next_task),
    .next_stack    (next_stack),
    .idle_chosen   (idle_chosen)
  );

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the priority ready queue scheduler
// holds its own scheduler predictor and compares every done transfer with it
// depends on prqs_pkg and the priority_ready_queue_scheduler rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                         status;
    logic [prqs_pkg::T_W-1:0]     task_nr;
    logic [prqs_pkg::STACK_W-1:0] stack;
    logic                         idle;
  } sched_answer_t;

  // clock, reset and block inputs, all known from time zero
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         cmd = prqs_pkg::CMD_NOP;
  logic [3:0]         task_id = '0;
  logic [3:0]         task_priority = '0;
  logic [15:0]        stack_value = '0;
  logic               stack_ok = 1'b0;
  logic               busy;
  logic               done;
  logic               status_code;
  logic [3:0]         next_task;
  logic [15:0]        next_stack;
  logic               idle_chosen;

  always #5 clk = ~clk;

  priority_ready_queue_scheduler DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .task_id(task_id), .task_priority(task_priority), .stack_value(stack_value),
    .stack_ok(stack_ok), .done(done), .status_code(status_code),
    .next_task(next_task), .next_stack(next_stack), .idle_chosen(idle_chosen)
  );

  // predictor copy of the scheduler tables
  logic [prqs_pkg::STACK_W-1:0] pm_stack [prqs_pkg::NUM_TASKS];
  logic [prqs_pkg::PF_W-1:0]    pm_prio  [prqs_pkg::NUM_TASKS];
  prqs_pkg::task_state_t        pm_state [prqs_pkg::NUM_TASKS];
  logic [prqs_pkg::T_W-1:0]     pm_link  [prqs_pkg::NUM_TASKS];
  logic                         pm_queued [prqs_pkg::NUM_TASKS];
  logic                         pm_loaded [prqs_pkg::NUM_TASKS];
  logic [prqs_pkg::T_W-1:0]     pm_head [prqs_pkg::NUM_PRIO];
  logic [prqs_pkg::T_W-1:0]     pm_tail [prqs_pkg::NUM_PRIO];
  int unsigned                  pm_count [prqs_pkg::NUM_PRIO];
  logic [prqs_pkg::T_W-1:0]     pm_running;
  logic                         pm_run_valid;

  sched_answer_t answers_due[$];
  int unsigned   mismatches = 0;
  int unsigned   idle_pct = 0;

  function automatic void clear_scheduler();
    for (int t = 0; t < prqs_pkg::NUM_TASKS; t++) begin
      pm_stack[t] = '0; pm_prio[t] = '0; pm_state[t] = prqs_pkg::TS_DORMANT;
      pm_link[t] = '0; pm_queued[t] = 1'b0; pm_loaded[t] = 1'b0;
    end
    for (int p = 0; p < prqs_pkg::NUM_PRIO; p++) begin
      pm_head[p] = '0; pm_tail[p] = '0; pm_count[p] = 0;
    end
    pm_running = prqs_pkg::IDLE_SLOT;
    pm_run_valid = 1'b0;
  endfunction

  // mark ready and append to the list of its priority, returns status
  function automatic logic enqueue_task(logic [prqs_pkg::T_W-1:0] t);
    logic [prqs_pkg::PF_W-1:0] p;
    p = pm_prio[t];
    pm_state[t] = prqs_pkg::TS_READY;
    if (p >= prqs_pkg::NUM_PRIO) return 1'b1;
    if (pm_queued[t]) return 1'b0;
    pm_link[t] = '0;
    if (pm_count[p] == 0) pm_head[p] = t;
    else pm_link[pm_tail[p]] = t;
    pm_tail[p] = t;
    pm_count[p]++;
    pm_queued[t] = 1'b1;
    return 1'b0;
  endfunction

  function automatic sched_answer_t schedule_step(prqs_pkg::cmd_t c, logic [3:0] tid,
      logic [3:0] prio, logic [15:0] sv, logic ok);
    sched_answer_t a;
    logic found;
    logic [prqs_pkg::T_W-1:0] chosen;
    logic unused;
    a = '0;
    found = 1'b0;
    case (c)
      prqs_pkg::CMD_READY: a.status = enqueue_task(tid);
      prqs_pkg::CMD_LOAD: begin
        pm_prio[tid] = prio;
        pm_stack[tid] = sv;
        pm_loaded[tid] = 1'b1;
      end
      prqs_pkg::CMD_YIELD: begin
        if (pm_run_valid) begin
          if (sv != 0) pm_stack[pm_running] = sv;
          if (pm_running != prqs_pkg::IDLE_SLOT) begin
            if (ok) begin
              // a task readied while running is already queued
              if (pm_state[pm_running] == prqs_pkg::TS_RUNNING)
                unused = enqueue_task(pm_running);
            end else begin
              pm_state[pm_running] = prqs_pkg::TS_BLOCKED;
            end
          end else begin
            pm_state[pm_running] = prqs_pkg::TS_READY;
          end
        end
        chosen = prqs_pkg::IDLE_SLOT;
        for (int p = 0; p < prqs_pkg::NUM_PRIO; p++) begin
          if (!found && pm_count[p] > 0) begin
            chosen = pm_head[p];
            pm_head[p] = pm_link[chosen];
            pm_count[p]--;
            pm_queued[chosen] = 1'b0;
            found = 1'b1;
          end
        end
        a.idle = !found;
        pm_state[chosen] = prqs_pkg::TS_RUNNING;
        pm_running = chosen;
        pm_run_valid = 1'b1;
      end
      default: ;
    endcase
    a.task_nr = pm_running;
    a.stack = pm_run_valid ? pm_stack[pm_running] : '0;
    return a;
  endfunction

  // one command transfer; start stays high after acceptance so that a
  // back-to-back transfer never lowers and raises it in the same step
  task automatic send_command(prqs_pkg::cmd_t c, logic [3:0] tid, logic [3:0] prio,
      logic [15:0] sv, logic ok);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c; task_id <= tid; task_priority <= prio;
    stack_value <= sv; stack_ok <= ok;
    do @(posedge clk); while (busy);
    answers_due.push_back(schedule_step(c, tid, prio, sv, ok));
  endtask

  // wait until every answer is back, then let the block settle
  task automatic wait_drained();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // checks each done transfer against the oldest expected answer
  always @(posedge clk) begin
    sched_answer_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected done transfer at %0t", $realtime);
      end else begin
        want = answers_due.pop_front();
        if (status_code !== want.status || next_task !== want.task_nr ||
            next_stack !== want.stack || idle_chosen !== want.idle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: want st=%0d task=%0d stk=%h idle=%0d, got st=%0d task=%0d stk=%h idle=%0d",
                     $realtime, want.status, want.task_nr, want.stack, want.idle,
                     status_code, next_task, next_stack, idle_chosen);
        end
      end
    end
  end

  // directed corners: idle dispatch, repeated ready, bad priority,
  // load of a queued task, blocking, readied while running
  task automatic test_directed();
    send_command(prqs_pkg::CMD_LOAD, 4'd0, 4'd7, 16'hFFFF, 1'b1);
    send_command(prqs_pkg::CMD_NOP, 4'd15, 4'd15, 16'h0000, 1'b0);
    send_command(prqs_pkg::CMD_YIELD, 4'd0, 4'd0, 16'h0000, 1'b1);   // nothing running yet
    send_command(prqs_pkg::CMD_LOAD, 4'd1, 4'd0, 16'h1234, 1'b0);
    send_command(prqs_pkg::CMD_READY, 4'd1, 4'd0, 16'h0000, 1'b0);
    send_command(prqs_pkg::CMD_READY, 4'd1, 4'd0, 16'h0000, 1'b0);   // already queued
    send_command(prqs_pkg::CMD_YIELD, 4'd0, 4'd0, 16'h5555, 1'b0);   // idle yields
    send_command(prqs_pkg::CMD_LOAD, 4'd2, 4'd9, 16'h8001, 1'b1);
    send_command(prqs_pkg::CMD_READY, 4'd2, 4'd0, 16'h0000, 1'b1);   // priority out of range
    send_command(prqs_pkg::CMD_LOAD, 4'd15, 4'd15, 16'h0000, 1'b1);
    send_command(prqs_pkg::CMD_LOAD, 4'd4, 4'd3, 16'h4444, 1'b1);
    send_command(prqs_pkg::CMD_READY, 4'd4, 4'd0, 16'h0000, 1'b0);
    send_command(prqs_pkg::CMD_LOAD, 4'd4, 4'd5, 16'h4445, 1'b0);    // queued, stays put
    send_command(prqs_pkg::CMD_YIELD, 4'd0, 4'd0, 16'hABCD, 1'b1);   // requeue running
    send_command(prqs_pkg::CMD_READY, 4'd1, 4'd0, 16'h0000, 1'b0);   // readied while running
    send_command(prqs_pkg::CMD_YIELD, 4'd0, 4'd0, 16'h0000, 1'b0);   // blocked but queued
    send_command(prqs_pkg::CMD_READY, 4'd0, 4'd0, 16'h0000, 1'b0);
    send_command(prqs_pkg::CMD_YIELD, 4'd0, 4'd0, 16'h0000, 1'b1);
    send_command(prqs_pkg::CMD_YIELD, 4'd0, 4'd0, 16'hFFFF, 1'b0);
    send_command(prqs_pkg::CMD_YIELD, 4'd0, 4'd0, 16'h0001, 1'b1);
    send_command(prqs_pkg::CMD_YIELD, 4'd0, 4'd0, 16'h0000, 1'b1);
    wait_drained();
  endtask

  // random mix; ready only on loaded tasks so no unwritten entry is read
  task automatic test_random(int n, int pct);
    int r;
    logic [3:0] tid;
    logic [3:0] prio;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      tid = $urandom_range(15);
      prio = ($urandom_range(9) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(7));
      if (r < 35) begin
        while (!pm_loaded[tid]) tid = tid + 4'd1;
        send_command(prqs_pkg::CMD_READY, tid, 4'($urandom), 16'($urandom), 1'($urandom));
      end else if (r < 75) begin
        send_command(prqs_pkg::CMD_YIELD, 4'($urandom), 4'($urandom), 16'($urandom),
                     $urandom_range(4) != 0);
      end else if (r < 95) begin
        send_command(prqs_pkg::CMD_LOAD, tid, prio, 16'($urandom), 1'($urandom));
      end else begin
        send_command(prqs_pkg::CMD_NOP, tid, prio, 16'($urandom), 1'($urandom));
      end
    end
    wait_drained();
  endtask

  initial begin
    clear_scheduler();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500, 0);
    test_random(500, 82);
    test_random(700, 20);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("** priority_ready_queue_scheduler: PASSED **");
    end else begin
      $display("** priority_ready_queue_scheduler: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("** priority_ready_queue_scheduler: FAILED **");
    $finish;
  end
endmodule
